### rtl/core/keypad_debounce_long_press_repeat_core_defines.svh
// Assertion macros shared by the keypad debounce checker.
// No dependencies; the clock and reset must be named clk and arst_n where used.
`ifndef KEYPAD_DEBOUNCE_LONG_PRESS_REPEAT_CORE_DEFINES_SVH
`define KEYPAD_DEBOUNCE_LONG_PRESS_REPEAT_CORE_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define KDLPR_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("kdlpr: same-cycle check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define KDLPR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("kdlpr: next-cycle check failed");

`endif

### rtl/core/kdlpr_pkg.sv
// Shared types, codes and the key encoder for the keypad debounce core.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package kdlpr_pkg;

	localparam int KEY_COUNT = 9;
	localparam int CODE_W    = 4;
	localparam int COUNT_W   = 16;
	localparam int CFG_IDX_W = 2;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT     = 2'd1;

	localparam logic [COUNT_W-1:0] LONG_PRESS_RESET = 16'd100;
	localparam logic [COUNT_W-1:0] REPEAT_RESET     = 16'd20;

	// Scan codes.
	localparam logic [CODE_W-1:0] SCAN_NONE        = 4'd0;
	localparam logic [CODE_W-1:0] SCAN_RESET_COMBO = 4'd1;
	localparam logic [CODE_W-1:0] SCAN_CLEAR_COMBO = 4'd2;
	localparam logic [CODE_W-1:0] SCAN_KEY_BASE    = 4'd3;

	typedef enum logic [2:0] {
		EV_RAW    = 3'd0,
		EV_DOWN   = 3'd1,
		EV_LONG   = 3'd2,
		EV_REPEAT = 3'd3,
		EV_UP     = 3'd4
	} event_t;

	typedef enum logic [5:0] {
		PH_IDLE    = 6'b000001,
		PH_SETTLE  = 6'b000010,
		PH_CONFIRM = 6'b000100,
		PH_LONG    = 6'b001000,
		PH_REPEAT  = 6'b010000,
		PH_RELEASE = 6'b100000
	} phase_t;

	typedef struct packed {
		phase_t              phase;
		logic [COUNT_W-1:0]  hold_count;
		logic [CODE_W-1:0]   previous_key;
		logic [CODE_W-1:0]   latched_key;
	} state_t;

	// Priority encoder: the two combinations first, then the lowest key number.
	function automatic logic [CODE_W-1:0] encode_keys(input logic [KEY_COUNT-1:0] keys_low);
		logic [KEY_COUNT-1:0] p;
		logic [CODE_W-1:0]    c;
		p = ~keys_low;
		c = SCAN_NONE;
		if (p[4] && p[3]) begin
			c = SCAN_RESET_COMBO;
		end else if (p[4] && p[7]) begin
			c = SCAN_CLEAR_COMBO;
		end else begin
			for (int i = KEY_COUNT - 1; i >= 0; i--) begin
				if (p[i]) begin
					c = SCAN_KEY_BASE + CODE_W'(i);
				end
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

### rtl/core/keypad_debounce_long_press_repeat_core.sv
// Keypad debounce core with long-press detection and auto-repeat, one scan tick per transfer.
// Depends on kdlpr_pkg and kdlpr_step.
//
// Each input transfer is one scan tick of nine active-low key levels and yields exactly one
// result transfer (event, scan code, held key). The block takes one tick every clock cycle
// unless the result side stalls: a tick is captured in an input register, then the state
// machine and hold counter update as the result is written to the output register. The
// output register lets a new tick enter while a finished result still waits; back-pressure
// on the result side stalls the input only when both registers are full. Configuration
// writes are taken at any time (cfg_ready is always high) but are meant to be done while no
// tick is in flight; indexes beyond the register list are ignored.
`timescale 1ns / 1ps
`default_nettype none

module keypad_debounce_long_press_repeat_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [kdlpr_pkg::KEY_COUNT-1:0]    keys_low,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [2:0]                         event_res,
	output logic [kdlpr_pkg::CODE_W-1:0]       scan_code,
	output logic [kdlpr_pkg::CODE_W-1:0]       held_key,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [kdlpr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [kdlpr_pkg::COUNT_W-1:0]      cfg_data
);

	logic                             valid_s1;
	logic [kdlpr_pkg::KEY_COUNT-1:0]  keys_s1;
	logic                             out_valid_q;
	kdlpr_pkg::event_t                event_q;
	logic [kdlpr_pkg::CODE_W-1:0]     scan_q;
	logic [kdlpr_pkg::CODE_W-1:0]     held_q;
	kdlpr_pkg::state_t                state_q;
	kdlpr_pkg::state_t                state_nxt;
	kdlpr_pkg::event_t                ev_nxt;
	logic [kdlpr_pkg::CODE_W-1:0]     code_nxt;
	logic [kdlpr_pkg::COUNT_W-1:0]    long_press_q;
	logic [kdlpr_pkg::COUNT_W-1:0]    repeat_q;
	logic                             advance;
	logic                             step_en;

	// The output register can take a new result when empty or being drained.
	assign advance  = !out_valid_q || out_ready;
	assign step_en  = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign event_res = event_q;
	assign scan_code = scan_q;
	assign held_key  = held_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_press_q <= kdlpr_pkg::LONG_PRESS_RESET;
			repeat_q     <= kdlpr_pkg::REPEAT_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == kdlpr_pkg::REG_LONG_PRESS) begin
				long_press_q <= cfg_data;
			end else if (cfg_index == kdlpr_pkg::REG_REPEAT) begin
				repeat_q <= cfg_data;
			end
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			keys_s1 <= keys_low;
		end
	end

	kdlpr_step u_step (
		.keys_low         (keys_s1),
		.long_press_ticks (long_press_q),
		.repeat_ticks     (repeat_q),
		.cur              (state_q),
		.nxt              (state_nxt),
		.ev               (ev_nxt),
		.code             (code_nxt)
	);

	// Machine state advances once per tick, as the tick moves to the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase        <= kdlpr_pkg::PH_IDLE;
			state_q.hold_count   <= '0;
			state_q.previous_key <= kdlpr_pkg::SCAN_NONE;
			state_q.latched_key  <= kdlpr_pkg::SCAN_NONE;
		end else if (step_en) begin
			state_q <= state_nxt;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			event_q <= ev_nxt;
			scan_q  <= code_nxt;
			held_q  <= state_nxt.latched_key;
		end
	end

endmodule

`default_nettype wire

### rtl/core/kdlpr_step.sv
// Next-state and event logic of the debounce state machine for one scan tick.
// Depends on kdlpr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kdlpr_step (
	input  logic [kdlpr_pkg::KEY_COUNT-1:0] keys_low,
	input  logic [kdlpr_pkg::COUNT_W-1:0]   long_press_ticks,
	input  logic [kdlpr_pkg::COUNT_W-1:0]   repeat_ticks,
	input  kdlpr_pkg::state_t               cur,
	output kdlpr_pkg::state_t               nxt,
	output kdlpr_pkg::event_t               ev,
	output logic [kdlpr_pkg::CODE_W-1:0]    code
);

	logic [kdlpr_pkg::COUNT_W-1:0] count_inc;

	assign code      = kdlpr_pkg::encode_keys(keys_low);
	assign count_inc = cur.hold_count + kdlpr_pkg::COUNT_W'(1);

	// The thresholds are compared against the count before it is incremented.
	always_comb begin
		nxt = cur;
		ev  = kdlpr_pkg::EV_RAW;
		case (cur.phase)
			kdlpr_pkg::PH_SETTLE: begin
				nxt.phase = kdlpr_pkg::PH_CONFIRM;
			end
			kdlpr_pkg::PH_CONFIRM: begin
				if (code != kdlpr_pkg::SCAN_NONE) begin
					nxt.latched_key  = code;
					nxt.previous_key = code;
					nxt.phase        = kdlpr_pkg::PH_LONG;
					ev               = kdlpr_pkg::EV_DOWN;
				end else begin
					nxt.phase = kdlpr_pkg::PH_RELEASE;
				end
			end
			kdlpr_pkg::PH_LONG: begin
				if (code != kdlpr_pkg::SCAN_NONE) begin
					nxt.hold_count = count_inc;
					if (cur.hold_count > long_press_ticks) begin
						nxt.phase      = kdlpr_pkg::PH_REPEAT;
						nxt.hold_count = '0;
						ev             = kdlpr_pkg::EV_LONG;
					end else begin
						// A different key restarts the confirmation.
						if (cur.previous_key != code) begin
							nxt.hold_count = '0;
							nxt.phase      = kdlpr_pkg::PH_CONFIRM;
						end
						ev = kdlpr_pkg::EV_DOWN;
					end
				end else begin
					nxt.phase = kdlpr_pkg::PH_RELEASE;
				end
			end
			kdlpr_pkg::PH_REPEAT: begin
				if (code != kdlpr_pkg::SCAN_NONE) begin
					if (cur.hold_count > repeat_ticks) begin
						nxt.hold_count = '0;
						ev             = kdlpr_pkg::EV_REPEAT;
					end else begin
						nxt.hold_count = count_inc;
						ev             = kdlpr_pkg::EV_LONG;
					end
				end else begin
					nxt.phase = kdlpr_pkg::PH_RELEASE;
				end
			end
			kdlpr_pkg::PH_RELEASE: begin
				nxt.hold_count = '0;
				nxt.phase      = kdlpr_pkg::PH_IDLE;
				ev             = kdlpr_pkg::EV_UP;
			end
			default: begin
				// Idle: any key starts the settle phase.
				if (code != kdlpr_pkg::SCAN_NONE) begin
					nxt.phase = kdlpr_pkg::PH_SETTLE;
				end else begin
					nxt.phase = kdlpr_pkg::PH_IDLE;
				end
			end
		endcase
	end

endmodule

`default_nettype wire

### rtl/core/kdlpr_checker.sv
// Port-level checks for the keypad debounce core, bound to the top level.
// Depends on kdlpr_pkg and keypad_debounce_long_press_repeat_core_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "keypad_debounce_long_press_repeat_core_defines.svh"

module kdlpr_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_ready,
	input logic [kdlpr_pkg::KEY_COUNT-1:0]    keys_low,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic [2:0]                         event_res,
	input logic [kdlpr_pkg::CODE_W-1:0]       scan_code,
	input logic [kdlpr_pkg::CODE_W-1:0]       held_key,
	input logic                               cfg_valid,
	input logic                               cfg_ready,
	input logic [kdlpr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input logic [kdlpr_pkg::COUNT_W-1:0]      cfg_data
);

	logic [kdlpr_pkg::CODE_W-1:0] last_held_q;
	logic                         out_xfer;
	logic                         key_event;
	logic                         unused_ok;

	assign out_xfer  = out_valid && out_ready;
	assign key_event = (event_res == kdlpr_pkg::EV_DOWN) || (event_res == kdlpr_pkg::EV_LONG) ||
		(event_res == kdlpr_pkg::EV_REPEAT);
	assign unused_ok = in_valid ^ in_ready ^ (^keys_low) ^ cfg_valid ^ cfg_ready ^
		(^cfg_index) ^ (^cfg_data);

	// Held key seen at the last result transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_held_q <= kdlpr_pkg::SCAN_NONE;
		end else if (out_xfer) begin
			last_held_q <= held_key;
		end
	end

	// A stalled result keeps its payload.
	`KDLPR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(event_res) && $stable(scan_code) && $stable(held_key) &&
		(unused_ok || !unused_ok))

	// Down, long and repeat events need a key in the current tick.
	`KDLPR_ASSERT_SAME(a_event_has_key, out_valid && key_event,
		scan_code != kdlpr_pkg::SCAN_NONE)

	// Once a press is confirmed the held key is never none on a key event.
	`KDLPR_ASSERT_SAME(a_held_valid, out_valid && key_event,
		held_key != kdlpr_pkg::SCAN_NONE)

	// The held key changes only with a confirmed press.
	`KDLPR_ASSERT_SAME(a_held_changes_on_down, out_xfer && (held_key != last_held_q),
		event_res == kdlpr_pkg::EV_DOWN)

endmodule

bind keypad_debounce_long_press_repeat_core kdlpr_checker u_kdlpr_checker (.*);

`default_nettype wire
